/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/avhd_pkg.sv */
package avhd_pkg;

    localparam int TYPE_CODE_W   = 8;
    localparam int BODY_LENGTH_W = 16;
    localparam int BODY_BYTES_W  = 64;
    localparam int BODY_NUM      = BODY_BYTES_W / 8;
    localparam int LEN_W         = 8;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hff;
    localparam logic [7:0] SIGN_MARKER   = 8'h80;
    localparam logic [7:0] WIDTH_MASK    = 8'h07;

    // zcl type codes and ranges
    localparam logic [7:0] TC_NO_DATA    = 8'h00;
    localparam logic [7:0] TC_DATA_LO    = 8'h08;
    localparam logic [7:0] TC_DATA_HI    = 8'h0f;
    localparam logic [7:0] TC_BOOL       = 8'h10;
    localparam logic [7:0] TC_BITMAP_LO  = 8'h18;
    localparam logic [7:0] TC_UINT_LO    = 8'h20;
    localparam logic [7:0] TC_INT_LO     = 8'h28;
    localparam logic [7:0] TC_INT_HI     = 8'h2f;
    localparam logic [7:0] TC_ENUM8      = 8'h30;
    localparam logic [7:0] TC_ENUM16     = 8'h31;
    localparam logic [7:0] TC_OCTET_STR  = 8'h41;
    localparam logic [7:0] TC_CHAR_STR   = 8'h42;

    typedef logic [TYPE_CODE_W-1:0]   type_code_t;
    typedef logic [BODY_LENGTH_W-1:0] body_length_t;
    typedef logic [BODY_BYTES_W-1:0]  body_bytes_t;
    typedef logic [LEN_W-1:0]         len_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_TRUNCATED   = 2'd2,
        ST_INVALID     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SHAPE_RAW      = 3'd0,
        SHAPE_UNSIGNED = 3'd1,
        SHAPE_SIGNED   = 3'd2,
        SHAPE_BOOL     = 3'd3,
        SHAPE_TEXT     = 3'd4
    } shape_t;

endpackage

/* sv/avhd_if.sv */
interface avhd_item_if import avhd_pkg::*; ();
    logic         valid;
    logic         ready;
    type_code_t   type_code;
    body_length_t body_length;
    body_bytes_t  body_bytes;

    modport source (output valid, output type_code, output body_length, output body_bytes,
                    input ready);
    modport sink   (input valid, input type_code, input body_length, input body_bytes,
                    output ready);
endinterface

interface avhd_result_if import avhd_pkg::*; ();
    logic    valid;
    logic    ready;
    status_t status;
    logic    payload_offset;
    len_t    payload_length;
    len_t    total_length;
    logic    is_non_value;

    modport source (output valid, output status, output payload_offset, output payload_length,
                    output total_length, output is_non_value, input ready);
    modport sink   (input valid, input status, input payload_offset, input payload_length,
                    input total_length, input is_non_value, output ready);
endinterface

/* sv/attribute_value_header_decoder.sv */
// order: an accepted request fills the input register, then moves on into the result register
// throughput: one request per cycle while the result is taken, the registers form a two-deep pipeline
// a stalled result holds in the result register while one more request waits in the input one
// reset: rst_n asynchronous active low clears both valid flags, payload registers are not reset
`include "assert_macros.svh"

module attribute_value_header_decoder import avhd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    avhd_item_if.sink            item,
    avhd_result_if.source        result
);

    // input register
    logic         in_valid_reg;
    type_code_t   type_code_reg;
    body_length_t body_length_reg;
    body_bytes_t  body_bytes_reg;

    // result register
    logic         out_valid_reg;
    status_t      status_reg;
    logic         payload_offset_reg;
    len_t         payload_length_reg;
    len_t         total_length_reg;
    logic         is_non_value_reg;

    logic out_free;
    logic in_advance;

    assign out_free   = !out_valid_reg || result.ready;
    assign in_advance = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;

    // decode
    logic         supported;
    shape_t       shape;
    logic [3:0]   fixed_width;
    logic [7:0]   b0;
    logic         offset;
    len_t         width;
    logic [8:0]   needed;
    logic         marker;
    logic [BODY_NUM-1:0] byte_ones;
    logic [BODY_NUM-1:0] byte_zero;
    logic [BODY_NUM-1:0] byte_sign;
    logic         unsigned_nv;
    logic         signed_nv;
    status_t      status_next;
    logic         payload_offset_next;
    len_t         payload_length_next;
    len_t         total_length_next;
    logic         is_non_value_next;

    assign b0          = body_bytes_reg[7:0];
    assign fixed_width = {1'b0, type_code_reg[2:0] & WIDTH_MASK[2:0]} + 4'd1;

    always_comb
    begin
        supported = 1'b1;
        shape     = SHAPE_RAW;
        priority if (type_code_reg == TC_NO_DATA)
        begin
            shape = SHAPE_RAW;
        end
        else if (type_code_reg >= TC_DATA_LO && type_code_reg <= TC_DATA_HI)
        begin
            shape = SHAPE_RAW;
        end
        else if (type_code_reg >= TC_BITMAP_LO && type_code_reg <= TC_INT_HI)
        begin
            if (type_code_reg >= TC_INT_LO)
                shape = SHAPE_SIGNED;
            else if (type_code_reg >= TC_UINT_LO)
                shape = SHAPE_UNSIGNED;
            else
                shape = SHAPE_RAW;
        end
        else if (type_code_reg == TC_BOOL)
        begin
            shape = SHAPE_BOOL;
        end
        else if (type_code_reg == TC_ENUM8 || type_code_reg == TC_ENUM16)
        begin
            shape = SHAPE_UNSIGNED;
        end
        else if (type_code_reg == TC_OCTET_STR || type_code_reg == TC_CHAR_STR)
        begin
            shape = SHAPE_TEXT;
        end
        else
        begin
            supported = 1'b0;
        end
    end

    // per-byte marker compares, byte i only counts below the width
    always_comb
    begin
        for (int i = 0; i < BODY_NUM; i++)
        begin
            byte_ones[i] = (body_bytes_reg[8*i +: 8] == BYTE_ALL_ONES)
                           || (4'(i) >= fixed_width);
            byte_zero[i] = (body_bytes_reg[8*i +: 8] == 8'h00)
                           || (4'(i) >= fixed_width - 4'd1);
            byte_sign[i] = (body_bytes_reg[8*i +: 8] == SIGN_MARKER)
                           || (4'(i) != fixed_width - 4'd1);
        end
    end

    assign unsigned_nv = &byte_ones;
    assign signed_nv   = (&byte_zero) && (&byte_sign);

    always_comb
    begin
        offset = 1'b0;
        width  = (type_code_reg == TC_NO_DATA) ? '0 : len_t'(fixed_width);
        marker = 1'b0;
        unique case (shape)
            SHAPE_TEXT:
            begin
                offset = 1'b1;
                marker = (b0 == BYTE_ALL_ONES);
                width  = marker ? '0 : b0;
            end
            SHAPE_SIGNED:              marker = signed_nv;
            SHAPE_UNSIGNED, SHAPE_BOOL: marker = unsigned_nv;
            default:                   marker = 1'b0;
        endcase
    end

    assign needed = {8'd0, offset} + {1'b0, width};

    always_comb
    begin
        status_next         = ST_OK;
        payload_offset_next = 1'b0;
        payload_length_next = '0;
        total_length_next   = '0;
        is_non_value_next   = 1'b0;
        priority if (!supported)
            status_next = ST_UNSUPPORTED;
        else if (shape == SHAPE_TEXT && body_length_reg == '0)
            status_next = ST_TRUNCATED;
        else if (body_length_reg < {7'd0, needed})
            status_next = ST_TRUNCATED;
        else if (shape == SHAPE_BOOL && b0 != 8'h00 && b0 != 8'h01 && b0 != BYTE_ALL_ONES)
            status_next = ST_INVALID;
        else
        begin
            payload_offset_next = offset;
            payload_length_next = width;
            total_length_next   = needed[LEN_W-1:0];
            is_non_value_next   = marker;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            type_code_reg   <= item.type_code;
            body_length_reg <= item.body_length;
            body_bytes_reg  <= item.body_bytes;
        end
        if (in_advance)
        begin
            status_reg         <= status_next;
            payload_offset_reg <= payload_offset_next;
            payload_length_reg <= payload_length_next;
            total_length_reg   <= total_length_next;
            is_non_value_reg   <= is_non_value_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.payload_offset = payload_offset_reg;
    assign result.payload_length = payload_length_reg;
    assign result.total_length   = total_length_reg;
    assign result.is_non_value   = is_non_value_reg;

    `ASSERT_CLK(a_error_clears_fields,
        (out_valid_reg && status_reg != ST_OK) |-> (!payload_offset_reg
            && payload_length_reg == '0 && total_length_reg == '0 && !is_non_value_reg),
        "error result carries nonzero fields")
    `ASSERT_CLK(a_encoded_sum,
        out_valid_reg |-> (total_length_reg == payload_length_reg + len_t'(payload_offset_reg)),
        "total length is not offset plus payload length")
    `ASSERT_CLK(a_full_blocks_request,
        (in_valid_reg && out_valid_reg && !result.ready) |-> !item.ready,
        "request taken while both stages are full")
    `ASSERT_ALWAYS(a_reset_no_result, !rst_n |-> !out_valid_reg, "result valid during reset")

endmodule
